[hdl/gbi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared types and codes for the grid bilinear interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

    typedef enum logic [1:0] {
        OP_WR_STRIKE   = 2'd0,
        OP_WR_MATURITY = 2'd1,
        OP_WR_GRID     = 2'd2,
        OP_QUERY       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_STRIKE_COUNT   = 2'd0,
        REG_MATURITY_COUNT = 2'd1,
        REG_VARIANCE_MODE  = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN_S,
        ST_SCAN_M,
        ST_FETCH_AXES,
        ST_WAIT_AXES,
        ST_LATCH_AXES,
        ST_RD11,
        ST_RD12,
        ST_RD21,
        ST_RD22,
        ST_CHECK,
        ST_DIV_X_START,
        ST_DIV_X,
        ST_DIV_Y_START,
        ST_DIV_Y,
        ST_BLEND_A,
        ST_BLEND_A_ADD,
        ST_BLEND_B,
        ST_BLEND_B_ADD,
        ST_BLEND_R,
        ST_BLEND_R_ADD,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

[hdl/gbi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbi_in_if / gbi_out_if
// Valid/ready channels that carry the query and result items.
// ----------------------------------------------------------------------------
interface gbi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] write_value;
    logic signed [31:0] query_x;
    logic [30:0] query_maturity;

    modport source (output valid, operation, row, col, write_value, query_x,
                    query_maturity, input ready);
    modport sink (input valid, operation, row, col, write_value, query_x,
                  query_maturity, output ready);
endinterface

interface gbi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] volatility;
    logic        saturated;

    modport source (output valid, volatility, saturated, input ready);
    modport sink (input valid, volatility, saturated, output ready);
endinterface

[hdl/gbi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One address per cycle; a write cycle also returns the old word. Read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/grid_bilinear_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_top
// Bilinear interpolation over a loaded rectilinear grid in signed Q16.16.
// ----------------------------------------------------------------------------
//  channel | direction | content
//  in_ch   | sink      | operation, row, col, write_value, query_x, query_maturity
//  out_ch  | source    | volatility, saturated (one item per query)
//  apb     | slave     | strike_count, maturity_count, variance_mode
//
//  A write item is taken while the block is idle, and the block stays ready
//  for the next. A query holds the block until its result is taken: the axis
//  scans read up to the effective strike and maturity counts of entries, one
//  per cycle, and the shared restoring divider computes each weight in turn.
//  Equal bounds on either axis skip the divisions and blends. After reset the
//  whole grid is cleared, one entry per cycle, before the first item is taken.
//  A result waits in the output register while out_ch.ready is low.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_top #(
    parameter int MAX_STRIKES    = 16,
    parameter int MAX_MATURITIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    gbi_in_if.sink      in_ch,
    gbi_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(MAX_STRIKES);
    localparam int MW = $clog2(MAX_MATURITIES);
    localparam int GD = MAX_STRIKES * MAX_MATURITIES;
    localparam int GW = SW + MW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0] strike_count_reg;
    logic [4:0] maturity_count_reg;
    logic       variance_mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_count_reg   <= 5'd1;
            maturity_count_reg <= 5'd1;
            variance_mode_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gbi_pkg::REG_STRIKE_COUNT:   strike_count_reg   <= pwdata[4:0];
                gbi_pkg::REG_MATURITY_COUNT: maturity_count_reg <= pwdata[4:0];
                gbi_pkg::REG_VARIANCE_MODE:  variance_mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gbi_pkg::REG_STRIKE_COUNT:   prdata = {27'd0, strike_count_reg};
            gbi_pkg::REG_MATURITY_COUNT: prdata = {27'd0, maturity_count_reg};
            gbi_pkg::REG_VARIANCE_MODE:  prdata = {31'd0, variance_mode_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Effective counts: zero acts as one, above the depth acts as the depth.
    logic [SW:0] ns_eff;
    logic [MW:0] nm_eff;
    always_comb
    begin
        if (strike_count_reg == 5'd0)
            ns_eff = (SW+1)'(1);
        else if (32'(strike_count_reg) > MAX_STRIKES)
            ns_eff = (SW+1)'(MAX_STRIKES);
        else
            ns_eff = (SW+1)'(strike_count_reg);
        if (maturity_count_reg == 5'd0)
            nm_eff = (MW+1)'(1);
        else if (32'(maturity_count_reg) > MAX_MATURITIES)
            nm_eff = (MW+1)'(MAX_MATURITIES);
        else
            nm_eff = (MW+1)'(maturity_count_reg);
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic          s_we, m_we, g_we;
    logic [SW-1:0] s_addr;
    logic [MW-1:0] m_addr;
    logic [GW-1:0] g_addr;
    logic [31:0]   s_wdata, m_wdata, g_wdata;
    logic [31:0]   s_rdata, m_rdata, g_rdata;

    gbi_ram #(.WIDTH(32), .DEPTH(MAX_STRIKES)) u_strike_ram (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
    gbi_ram #(.WIDTH(32), .DEPTH(MAX_MATURITIES)) u_maturity_ram (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
    gbi_ram #(.WIDTH(32), .DEPTH(GD)) u_grid_ram (
        .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata));

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    gbi_pkg::state_t state_reg, state_next;
    logic            clr_busy_reg;
    logic [GW:0]     clr_cnt_reg;

    logic signed [31:0] qx_reg, qm_reg;
    logic [SW:0]        sidx_reg, sidx_next;
    logic [MW:0]        midx_reg, midx_next;
    logic               spend_reg;                 // scan read in flight
    logic [SW:0]        spos_reg, spos_next;
    logic [MW:0]        mpos_reg, mpos_next;
    logic [SW-1:0]      i1_reg, i2_reg;
    logic [MW-1:0]      j1_reg, j2_reg;
    logic signed [31:0] s1_reg, s2_reg, m1_reg, m2_reg;
    logic               ahalf_reg;
    logic signed [31:0] v11_reg, v12_reg, v21_reg, v22_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic signed [31:0] a_reg, b_reg, r_reg;
    logic signed [63:0] prod_reg;
    logic               flag_reg;

    // Shared restoring divider: unsigned 48-bit numerator by 33-bit divisor.
    logic [47:0] dq_reg;
    logic [33:0] drem_reg;
    logic [32:0] dden_reg;
    logic        dneg_reg;
    logic [5:0]  dcnt_reg;

    logic signed [31:0] out_vol_reg;
    logic               out_sat_reg;
    logic               out_valid_reg;

    // Bracket clamp given a lower-bound position.
    function automatic logic [8:0] clamp_pos(input logic [8:0] pos,
                                             input logic [8:0] n);
        logic [8:0] p;
        begin
            p = pos;
            if (p == 9'd0) p = 9'd1;
            if (p >= n) p = n - 9'd1;
            return p;
        end
    endfunction

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic [32:0] sat34(input logic signed [33:0] v);
        begin
            if (v > 34'sh0_7FFF_FFFF) return {1'b1, gbi_pkg::S32_MAX};
            if (v < -34'sh0_8000_0000) return {1'b1, gbi_pkg::S32_MIN};
            return {1'b0, v[31:0]};
        end
    endfunction

    // Saturate a 50-bit signed blend sum to 32 bits.
    function automatic logic [32:0] sat50(input logic signed [49:0] v);
        begin
            if (v > 50'sh7FFF_FFFF) return {1'b1, gbi_pkg::S32_MAX};
            if (v < -50'sh8000_0000) return {1'b1, gbi_pkg::S32_MIN};
            return {1'b0, v[31:0]};
        end
    endfunction

    // Divider operands chosen by the sequencer.
    logic signed [33:0] num_diff, den_diff;
    logic [33:0]        rem_try;

    always_comb
    begin
        if (state_reg == gbi_pkg::ST_DIV_X_START)
        begin
            num_diff = 34'(qx_reg) - 34'(s1_reg);
            den_diff = 34'(s2_reg) - 34'(s1_reg);
        end
        else
        begin
            num_diff = 34'(qm_reg) - 34'(m1_reg);
            den_diff = 34'(m2_reg) - 34'(m1_reg);
        end
        rem_try = {drem_reg[32:0], dq_reg[47]} - {1'b0, dden_reg};
    end

    // Blend multiplier operands: one 32x33 multiply per blend.
    logic signed [31:0] bl_w;
    logic signed [31:0] bl_lo, bl_hi;
    logic signed [32:0] bl_diff;
    logic signed [64:0] bl_sum;
    logic signed [49:0] bl_res;
    logic [32:0]        bl_sat;

    always_comb
    begin
        unique case (state_reg)
            gbi_pkg::ST_BLEND_A, gbi_pkg::ST_BLEND_A_ADD:
            begin
                bl_lo = v11_reg; bl_hi = v21_reg; bl_w = tx_reg;
            end
            gbi_pkg::ST_BLEND_B, gbi_pkg::ST_BLEND_B_ADD:
            begin
                bl_lo = v12_reg; bl_hi = v22_reg; bl_w = tx_reg;
            end
            default:
            begin
                bl_lo = a_reg; bl_hi = b_reg; bl_w = ty_reg;
            end
        endcase
        bl_diff = 33'(bl_hi) - 33'(bl_lo);
        bl_sum  = 65'(prod_reg) + 65'sd32768;
        bl_res  = 50'(bl_lo) + 50'(bl_sum >>> 16);
        bl_sat  = sat50(bl_res);
    end

    // Memory access and sequencer.
    logic        in_fire;
    logic [8:0]  s_pick, m_pick;
    logic [32:0] q_sat;
    logic signed [33:0] abs_r;
    logic [32:0] abs_sat;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == gbi_pkg::ST_IDLE) && !clr_busy_reg;

    always_comb
    begin
        s_pick  = clamp_pos(9'(spos_reg), 9'(ns_eff));
        m_pick  = clamp_pos(9'(mpos_next), 9'(nm_eff));
        // Signed quotient saturation.
        if (dneg_reg)
            q_sat = (dq_reg > 48'h8000_0000) ? {1'b1, gbi_pkg::S32_MIN}
                                             : {1'b0, 32'(-dq_reg)};
        else
            q_sat = (dq_reg > 48'h7FFF_FFFF) ? {1'b1, gbi_pkg::S32_MAX}
                                             : {1'b0, dq_reg[31:0]};
        abs_r   = r_reg[31] ? -34'(r_reg) : 34'(r_reg);
        abs_sat = sat34(abs_r);
    end

    always_comb
    begin
        s_we = 1'b0; m_we = 1'b0; g_we = 1'b0;
        s_addr = SW'(sidx_reg); m_addr = MW'(midx_reg);
        g_addr = {i1_reg, j1_reg};
        s_wdata = in_ch.write_value; m_wdata = in_ch.write_value;
        g_wdata = in_ch.write_value;
        state_next = state_reg;
        sidx_next  = sidx_reg;
        midx_next  = midx_reg;
        spos_next  = spos_reg;
        mpos_next  = mpos_reg;

        if (clr_busy_reg)
        begin
            g_we = 1'b1;
            g_addr = GW'(clr_cnt_reg);
            g_wdata = 32'd0;
        end
        else
        begin
            unique case (state_reg)
                gbi_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (gbi_pkg::op_t'(in_ch.operation))
                            gbi_pkg::OP_WR_STRIKE:
                            begin
                                s_we = 32'(in_ch.row) < MAX_STRIKES;
                                s_addr = SW'(in_ch.row);
                            end
                            gbi_pkg::OP_WR_MATURITY:
                            begin
                                m_we = 32'(in_ch.col) < MAX_MATURITIES;
                                m_addr = MW'(in_ch.col);
                            end
                            gbi_pkg::OP_WR_GRID:
                            begin
                                g_we = (32'(in_ch.row) < MAX_STRIKES) &&
                                       (32'(in_ch.col) < MAX_MATURITIES);
                                g_addr = {SW'(in_ch.row), MW'(in_ch.col)};
                            end
                            gbi_pkg::OP_QUERY:
                            begin
                                state_next = gbi_pkg::ST_SCAN_S;
                                sidx_next  = '0;
                                midx_next  = '0;
                                spos_next  = ns_eff;
                                mpos_next  = nm_eff;
                            end
                            default: ;
                        endcase
                    end
                end
                // Strike scan: read entry sidx, compare once data returns.
                gbi_pkg::ST_SCAN_S:
                begin
                    if (spend_reg)
                    begin
                        if ($signed(s_rdata) >= qx_reg)
                        begin
                            spos_next  = sidx_reg;
                            state_next = gbi_pkg::ST_SCAN_M;
                        end
                        else if (sidx_reg + 1'b1 >= ns_eff)
                            state_next = gbi_pkg::ST_SCAN_M;
                        else
                            sidx_next = sidx_reg + 1'b1;
                    end
                    s_addr = SW'(sidx_next);
                end
                gbi_pkg::ST_SCAN_M:
                begin
                    if (spend_reg)
                    begin
                        if ($signed(m_rdata) >= qm_reg)
                        begin
                            mpos_next  = midx_reg;
                            state_next = gbi_pkg::ST_FETCH_AXES;
                        end
                        else if (midx_reg + 1'b1 >= nm_eff)
                            state_next = gbi_pkg::ST_FETCH_AXES;
                        else
                            midx_next = midx_reg + 1'b1;
                    end
                    m_addr = MW'(midx_next);
                end
                // Two reads on each axis RAM: low bounds, then high bounds.
                gbi_pkg::ST_FETCH_AXES:
                begin
                    s_addr = i1_reg; m_addr = j1_reg;
                    state_next = gbi_pkg::ST_WAIT_AXES;
                end
                gbi_pkg::ST_WAIT_AXES:
                begin
                    s_addr = i2_reg; m_addr = j2_reg;
                    state_next = gbi_pkg::ST_LATCH_AXES;
                end
                gbi_pkg::ST_LATCH_AXES:
                begin
                    g_addr = {i1_reg, j1_reg};
                    state_next = gbi_pkg::ST_RD11;
                end
                gbi_pkg::ST_RD11:
                begin
                    g_addr = {i1_reg, j2_reg};
                    state_next = gbi_pkg::ST_RD12;
                end
                gbi_pkg::ST_RD12:
                begin
                    g_addr = {i2_reg, j1_reg};
                    state_next = gbi_pkg::ST_RD21;
                end
                gbi_pkg::ST_RD21:
                begin
                    g_addr = {i2_reg, j2_reg};
                    state_next = gbi_pkg::ST_RD22;
                end
                gbi_pkg::ST_RD22:   state_next = gbi_pkg::ST_CHECK;
                gbi_pkg::ST_CHECK:
                begin
                    if (s1_reg == s2_reg || m1_reg == m2_reg)
                        state_next = gbi_pkg::ST_FINISH;
                    else
                        state_next = gbi_pkg::ST_DIV_X_START;
                end
                gbi_pkg::ST_DIV_X_START: state_next = gbi_pkg::ST_DIV_X;
                gbi_pkg::ST_DIV_X:
                    if (dcnt_reg == 6'd0) state_next = gbi_pkg::ST_DIV_Y_START;
                gbi_pkg::ST_DIV_Y_START: state_next = gbi_pkg::ST_DIV_Y;
                gbi_pkg::ST_DIV_Y:
                    if (dcnt_reg == 6'd0) state_next = gbi_pkg::ST_BLEND_A;
                gbi_pkg::ST_BLEND_A:     state_next = gbi_pkg::ST_BLEND_A_ADD;
                gbi_pkg::ST_BLEND_A_ADD: state_next = gbi_pkg::ST_BLEND_B;
                gbi_pkg::ST_BLEND_B:     state_next = gbi_pkg::ST_BLEND_B_ADD;
                gbi_pkg::ST_BLEND_B_ADD: state_next = gbi_pkg::ST_BLEND_R;
                gbi_pkg::ST_BLEND_R:     state_next = gbi_pkg::ST_BLEND_R_ADD;
                gbi_pkg::ST_BLEND_R_ADD: state_next = gbi_pkg::ST_FINISH;
                gbi_pkg::ST_FINISH:      state_next = gbi_pkg::ST_OUT;
                gbi_pkg::ST_OUT:
                    if (!out_valid_reg) state_next = gbi_pkg::ST_IDLE;
                default: state_next = gbi_pkg::ST_IDLE;
            endcase
        end
    end

    // State and reset sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gbi_pkg::ST_IDLE;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            spend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == GD - 1)
                    clr_busy_reg <= 1'b0;
            end
            // A scan read is valid in the cycle after its address was set.
            spend_reg <= (state_next == gbi_pkg::ST_SCAN_S ||
                          state_next == gbi_pkg::ST_SCAN_M) &&
                         (state_next == state_reg);
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        sidx_reg <= sidx_next;
        midx_reg <= midx_next;
        spos_reg <= spos_next;
        mpos_reg <= mpos_next;
        if (in_fire)
        begin
            qx_reg   <= in_ch.query_x;
            qm_reg   <= {1'b0, in_ch.query_maturity};
            flag_reg <= 1'b0;
        end
        unique case (state_reg)
            gbi_pkg::ST_SCAN_M:
            begin
                if (ns_eff == (SW+1)'(1))
                begin
                    i1_reg <= '0; i2_reg <= '0;
                end
                else
                begin
                    i1_reg <= SW'(s_pick - 9'd1); i2_reg <= SW'(s_pick);
                end
                if (nm_eff == (MW+1)'(1))
                begin
                    j1_reg <= '0; j2_reg <= '0;
                end
                else
                begin
                    j1_reg <= MW'(m_pick - 9'd1); j2_reg <= MW'(m_pick);
                end
            end
            gbi_pkg::ST_WAIT_AXES:  begin s1_reg <= s_rdata; m1_reg <= m_rdata; end
            gbi_pkg::ST_LATCH_AXES: begin s2_reg <= s_rdata; m2_reg <= m_rdata; end
            gbi_pkg::ST_RD11:       v11_reg <= g_rdata;
            gbi_pkg::ST_RD12:       v12_reg <= g_rdata;
            gbi_pkg::ST_RD21:       v21_reg <= g_rdata;
            gbi_pkg::ST_RD22:       v22_reg <= g_rdata;
            gbi_pkg::ST_DIV_X_START, gbi_pkg::ST_DIV_Y_START:
            begin
                dneg_reg <= num_diff[33] ^ den_diff[33];
                dq_reg   <= {(num_diff[33] ? 32'(-num_diff) : 32'(num_diff)),
                             16'd0};
                dden_reg <= den_diff[33] ? 33'(-den_diff) : 33'(den_diff);
                drem_reg <= '0;
                dcnt_reg <= 6'd48;
            end
            gbi_pkg::ST_DIV_X, gbi_pkg::ST_DIV_Y:
            begin
                if (dcnt_reg != 6'd0)
                begin
                    // One quotient bit per cycle.
                    if (!rem_try[33])
                    begin
                        drem_reg <= rem_try;
                        dq_reg   <= {dq_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= {drem_reg[32:0], dq_reg[47]};
                        dq_reg   <= {dq_reg[46:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                else
                begin
                    if (state_reg == gbi_pkg::ST_DIV_X)
                        tx_reg <= q_sat[31:0];
                    else
                        ty_reg <= q_sat[31:0];
                    flag_reg <= flag_reg | q_sat[32];
                end
            end
            gbi_pkg::ST_BLEND_A, gbi_pkg::ST_BLEND_B, gbi_pkg::ST_BLEND_R:
                prod_reg <= 64'(bl_w * bl_diff);
            gbi_pkg::ST_BLEND_A_ADD:
            begin
                a_reg <= bl_sat[31:0]; flag_reg <= flag_reg | bl_sat[32];
            end
            gbi_pkg::ST_BLEND_B_ADD:
            begin
                b_reg <= bl_sat[31:0]; flag_reg <= flag_reg | bl_sat[32];
            end
            gbi_pkg::ST_BLEND_R_ADD:
            begin
                r_reg <= bl_sat[31:0]; flag_reg <= flag_reg | bl_sat[32];
            end
            gbi_pkg::ST_CHECK:
                if (s1_reg == s2_reg || m1_reg == m2_reg)
                    r_reg <= v11_reg;
            gbi_pkg::ST_FINISH:
            begin
                if (variance_mode_reg)
                begin
                    out_vol_reg <= abs_sat[31:0];
                    out_sat_reg <= flag_reg | abs_sat[32];
                end
                else
                begin
                    out_vol_reg <= r_reg;
                    out_sat_reg <= flag_reg;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == gbi_pkg::ST_FINISH)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.volatility = out_vol_reg;
    assign out_ch.saturated  = out_sat_reg;

    // Assertions.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == gbi_pkg::ST_IDLE && !clr_busy_reg)
        else $error("item accepted while busy");
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == gbi_pkg::ST_FINISH)
        else $error("result without finished query");
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_we && !m_we)
        else $error("axis write during grid clear");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gbi_pkg::ST_DIV_X_START |=> dcnt_reg == 6'd48)
        else $error("divider not loaded");

endmodule

[test/tb_grid_bilinear_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolator_top
// The testbench loads the axes and the grid, then sends directed and random
// write and query items through three idling phases and several register
// settings. A scoreboard predicts each interpolated value and its saturation
// flag in Q16.16 and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_grid_bilinear_interpolator_top;

    localparam int NS = 16;
    localparam int NM = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        gbi_pkg::op_t       op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] wval;
        logic signed [31:0] qx;
        logic [30:0]        qm;
    } grid_item_t;

    typedef struct {
        logic signed [31:0] vol;
        logic               sat;
    } vol_result_t;

    // Scoreboard: keeps its own copy of the tables and registers and
    // queues the expected interpolation result for every accepted query.
    class vol_scoreboard;
        int signed   strike_pts[NS];
        int signed   mat_pts[NM];
        int signed   surface[NS*NM];
        int unsigned n_strike = 1;
        int unsigned n_mat = 1;
        bit          abs_mode = 0;
        vol_result_t pending[$];
        bit          failed = 0;

        function new();
            foreach (surface[i]) surface[i] = 0;
            foreach (strike_pts[i]) strike_pts[i] = 0;
            foreach (mat_pts[i]) mat_pts[i] = 0;
        endfunction

        function longint clip32(longint v, ref bit flag);
            if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function int unsigned usable(int unsigned c, int unsigned depth);
            if (c == 0) return 1;
            if (c > depth) return depth;
            return c;
        endfunction

        // First entry not below the key, clamped to a valid cell.
        function void find_cell(int signed pts[], int unsigned n, longint key,
                                output int unsigned lo, output int unsigned hi);
            int unsigned pos;
            pos = n;
            for (int unsigned i = 0; i < n; i++)
                if (longint'(pts[i]) >= key) begin pos = i; break; end
            if (n == 1) begin lo = 0; hi = 0; return; end
            if (pos == 0) pos = 1;
            if (pos >= n) pos = n - 1;
            lo = pos - 1;
            hi = pos;
        endfunction

        function longint frac_weight(longint q, longint lo, longint hi, ref bit flag);
            return clip32(((q - lo) * 65536) / (hi - lo), flag);
        endfunction

        function longint mix(longint lo, longint hi, longint w, ref bit flag);
            longint p;
            p = w * (hi - lo);
            return clip32(lo + ((p + 32768) >>> 16), flag);
        endfunction

        function void note_input(grid_item_t it);
            int unsigned i1, i2, j1, j2;
            longint r, tx, ty, a, b;
            bit flag;
            vol_result_t res;
            int signed sp[], mp[];
            case (it.op)
                gbi_pkg::OP_WR_STRIKE:   strike_pts[it.row] = it.wval;
                gbi_pkg::OP_WR_MATURITY: mat_pts[it.col] = it.wval;
                gbi_pkg::OP_WR_GRID:     surface[it.row*NM + it.col] = it.wval;
                default:
                begin
                    flag = 0;
                    sp = strike_pts;
                    mp = mat_pts;
                    find_cell(sp, usable(n_strike, NS), longint'(it.qx), i1, i2);
                    find_cell(mp, usable(n_mat, NM), longint'({1'b0, it.qm}), j1, j2);
                    r = surface[i1*NM + j1];
                    if (strike_pts[i1] != strike_pts[i2] && mat_pts[j1] != mat_pts[j2])
                    begin
                        tx = frac_weight(it.qx, strike_pts[i1], strike_pts[i2], flag);
                        ty = frac_weight(longint'({1'b0, it.qm}), mat_pts[j1],
                                         mat_pts[j2], flag);
                        a = mix(surface[i1*NM + j1], surface[i2*NM + j1], tx, flag);
                        b = mix(surface[i1*NM + j2], surface[i2*NM + j2], tx, flag);
                        r = mix(a, b, ty, flag);
                    end
                    if (abs_mode)
                    begin
                        if (r < 0) r = -r;
                        r = clip32(r, flag);
                    end
                    res.vol = r[31:0];
                    res.sat = flag;
                    pending.insert(pending.size(), res);
                end
            endcase
        endfunction

        function void check_result(logic signed [31:0] vol, logic sat);
            vol_result_t exp_res;
            if (pending.size() == 0)
            begin
                $error("unexpected result item: volatility %0d saturated %0b", vol, sat);
                failed = 1;
                return;
            end
            exp_res = pending.pop_front();
            if (vol !== exp_res.vol)
            begin
                $error("volatility: expected %0d, actual %0d", exp_res.vol, vol);
                failed = 1;
            end
            if (sat !== exp_res.sat)
            begin
                $error("saturated: expected %0b, actual %0b", exp_res.sat, sat);
                failed = 1;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gbi_in_if  in_ch();
    gbi_out_if out_ch();

    grid_bilinear_interpolator_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    vol_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.operation = gbi_pkg::OP_QUERY;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.write_value = '0;
        in_ch.query_x = '0;
        in_ch.query_maturity = '0;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready = 0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor and watchdog on the rising edge.
    always @(posedge clk)
    begin
        grid_item_t it;
        bit moved;
        moved = 0;
        if (in_ch.valid && in_ch.ready)
        begin
            it.op = gbi_pkg::op_t'(in_ch.operation);
            it.row = in_ch.row;
            it.col = in_ch.col;
            it.wval = in_ch.write_value;
            it.qx = in_ch.query_x;
            it.qm = in_ch.query_maturity;
            sb.note_input(it);
            moved = 1;
        end
        if (out_ch.valid && out_ch.ready)
        begin
            sb.check_result(out_ch.volatility, out_ch.saturated);
            moved = 1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic reg_write(gbi_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = 4'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic set_regs(int unsigned ns, int unsigned nm, bit mode);
        reg_write(gbi_pkg::REG_STRIKE_COUNT, ns);
        reg_write(gbi_pkg::REG_MATURITY_COUNT, nm);
        reg_write(gbi_pkg::REG_VARIANCE_MODE, 32'(mode));
        sb.n_strike = ns & 5'h1f;
        sb.n_mat = nm & 5'h1f;
        sb.abs_mode = mode;
    endtask

    // Sends one item; valid stays high into the next item unless it idles.
    task automatic send_item(grid_item_t it);
        bit taken;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 0;
            @(negedge clk);
        end
        in_ch.valid = 1;
        in_ch.operation = it.op;
        in_ch.row = it.row;
        in_ch.col = it.col;
        in_ch.write_value = it.wval;
        in_ch.query_x = it.qx;
        in_ch.query_maturity = it.qm;
        do
        begin
            @(posedge clk);
            taken = in_ch.ready;
        end
        while (!taken);
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain();
        @(negedge clk);
        in_ch.valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic grid_item_t make_item(gbi_pkg::op_t op, int r, int c, int w,
                                             int x, int unsigned m);
        grid_item_t it;
        it.op = op;
        it.row = 4'(r);
        it.col = 4'(c);
        it.wval = w;
        it.qx = x;
        it.qm = 31'(m);
        return it;
    endfunction

    function automatic int unsigned pick_maturity();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(sb.mat_pts[NM-1] + 32'h20000, 0) & 32'h7fffffff;
        if (k < 85)
            return $urandom_range(sb.mat_pts[1], 0) & 32'h7fffffff;
        return $urandom() & 32'h7fffffff;
    endfunction

    function automatic grid_item_t random_item();
        int unsigned k;
        int lo, hi, idx;
        k = $urandom_range(99);
        if (k < 70)
        begin
            lo = sb.strike_pts[0] - 32'h20000;
            hi = sb.strike_pts[NS-1] + 32'h20000;
            if ($urandom_range(9) < 7 && lo < hi)
                return make_item(gbi_pkg::OP_QUERY, $urandom(), $urandom(), $urandom(),
                                 lo + int'($urandom_range(hi - lo)), pick_maturity());
            return make_item(gbi_pkg::OP_QUERY, $urandom(), $urandom(), $urandom(),
                             $urandom(), pick_maturity());
        end
        if (k < 88)
        begin
            if ($urandom_range(9) == 0)
                return make_item(gbi_pkg::OP_WR_GRID, $urandom(), $urandom(),
                                 $urandom(), 0, 0);
            return make_item(gbi_pkg::OP_WR_GRID, $urandom(), $urandom(),
                             int'($urandom_range(32'h000a0000)) - 32'h00050000,
                             $urandom(), $urandom());
        end
        // Axis rewrites: mostly a nudge, sometimes a copy of a neighbour.
        idx = $urandom_range(NS-1);
        if (k < 94)
        begin
            if ($urandom_range(3) == 0 && idx > 0)
                return make_item(gbi_pkg::OP_WR_STRIKE, idx, $urandom(),
                                 sb.strike_pts[idx-1], 0, 0);
            return make_item(gbi_pkg::OP_WR_STRIKE, idx, $urandom(),
                             sb.strike_pts[idx] + int'($urandom_range(32'h8000)) - 32'h4000,
                             0, 0);
        end
        if ($urandom_range(3) == 0 && idx > 0)
            return make_item(gbi_pkg::OP_WR_MATURITY, $urandom(), idx,
                             sb.mat_pts[idx-1], 0, 0);
        return make_item(gbi_pkg::OP_WR_MATURITY, $urandom(), idx,
                         (sb.mat_pts[idx] + int'($urandom_range(32'h8000))) & 32'h7fffffff,
                         0, 0);
    endfunction

    // Ascending axes with random spacing and a random grid.
    task automatic load_tables();
        int s, m;
        s = -int'($urandom_range(32'h00400000));
        m = $urandom_range(32'h00010000);
        for (int i = 0; i < NS; i++)
        begin
            send_item(make_item(gbi_pkg::OP_WR_STRIKE, i, $urandom(), s,
                                $urandom(), $urandom()));
            s = s + 1 + int'($urandom_range(32'h00080000));
        end
        for (int j = 0; j < NM; j++)
        begin
            send_item(make_item(gbi_pkg::OP_WR_MATURITY, $urandom(), j, m,
                                $urandom(), $urandom()));
            m = m + 1 + int'($urandom_range(32'h00040000));
        end
        for (int g = 0; g < NS*NM; g++)
            send_item(make_item(gbi_pkg::OP_WR_GRID, g / NM, g % NM,
                                int'($urandom_range(32'h00080000)) - 32'h00010000, 0, 0));
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Phase one: sender idles often, receiver idles more.
        send_idle_pct = 36;
        recv_idle_pct = 69;
        load_tables();
        drain();

        // Directed: single-entry axes, extremes and absolute value of the minimum.
        set_regs(1, 1, 1);
        send_item(make_item(gbi_pkg::OP_WR_GRID, 0, 0, gbi_pkg::S32_MIN, 0, 0));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, gbi_pkg::S32_MIN, 0));
        send_item(make_item(gbi_pkg::OP_QUERY, 15, 15, -1, gbi_pkg::S32_MAX,
                            31'h7fffffff));
        drain();
        set_regs(1, 1, 0);
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, 0, 31'h40000000));
        send_item(make_item(gbi_pkg::OP_WR_GRID, 15, 15, gbi_pkg::S32_MAX, 0, 0));
        send_item(make_item(gbi_pkg::OP_WR_GRID, 15, 0, gbi_pkg::S32_MIN, 0, 0));
        send_item(make_item(gbi_pkg::OP_WR_GRID, 0, 0, 32'h00010000, 0, 0));
        drain();
        set_regs(16, 16, 0);
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, gbi_pkg::S32_MIN, 0));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, gbi_pkg::S32_MAX, 31'h7fffffff));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, sb.strike_pts[15], sb.mat_pts[15]));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, sb.strike_pts[0], sb.mat_pts[0]));
        send_item(make_item(gbi_pkg::OP_WR_STRIKE, 5, 0, sb.strike_pts[4], 0, 0));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, sb.strike_pts[4], 31'h0));
        send_item(make_item(gbi_pkg::OP_WR_GRID, 14, 14, gbi_pkg::S32_MIN, 0, 0));
        send_item(make_item(gbi_pkg::OP_WR_GRID, 14, 15, gbi_pkg::S32_MAX, 0, 0));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, gbi_pkg::S32_MAX, 31'h7fffffff));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, 32'h55555555, 31'h2aaaaaaa));
        send_item(make_item(gbi_pkg::OP_QUERY, 0, 0, 0, 32'haaaaaaaa, 31'h55555555));
        run_random(80);
        drain();

        // Phase two: roles swapped; a zero count and one above the depth.
        send_idle_pct = 69;
        recv_idle_pct = 36;
        set_regs(0, 31, 1);
        run_random(40);
        drain();
        set_regs(7, 3, 0);
        run_random(40);
        drain();

        // Phase three: no idling, with one long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16, 16, 1);
        hold_cycles = 3000;
        run_random(50);
        drain();
        set_regs(2, 16, 0);
        run_random(34);
        drain();

        if (sb.failed || sb.pending.size() != 0)
            $display("Test completed with failures");
        else
            $display("Test completed successfully");
        $finish;
    end
endmodule
